// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the distance reply parser.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADRP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ADRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/adrp_pkg.sv -----
// Package of the distance reply parser: word types, codes and helpers.
// No dependencies; used by adrp_parse and ascii_distance_reply_parser_core.
package adrp_pkg;

    // Default byte budget of one reply.
    localparam int MAX_BYTES_DEF = 63;

    // Reset value of the range limit register.
    localparam logic [15:0] RANGE_LIMIT_RST = 16'd10000;

    // Characters the parser looks for.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_D     = 8'h64;

    // Action codes of an input word.
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_TIMEOUT = 1'b1;

    // Progress of the "d:" marker match.
    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_SAW_D  = 3'd1,
        PH_SPACES = 3'd2,
        PH_DIGITS = 3'd3,
        PH_DONE   = 3'd4,
        PH_FAILED = 3'd5
    } t_phase;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_RANGE   = 2'd2,
        ST_PARSE   = 2'd3
    } t_status;

    // One input word.
    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic       last;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] distance;
        logic        used_fallback;
    } t_out_word;

    // What the parse stage hands to the output register.
    typedef struct packed {
        logic      emit;
        t_out_word word;
    } t_step_res;

    // Decimal accumulate modulo 65536: v * 10 + d as two shifts and adds.
    function automatic logic [15:0] acc10(input logic [15:0] v, input logic [3:0] d);
        acc10 = (v << 3) + (v << 1) + {12'd0, d};
    endfunction

endpackage

// ----- rtl/ascii_distance_reply_parser_core.sv -----
// Top level of the distance reply parser: input register, parse stage,
// result register and the range limit register. Depends on adrp_pkg,
// adrp_parse and assert_macros.svh.
//
// Usage: reply bytes enter on the input channel (i_in_valid, o_in_stall,
// i_in_word) one word per cycle. A byte word with last set, or a timeout
// word, ends the reply and yields one result word on the output channel
// (o_out_valid, i_out_stall, o_out_word); other words yield nothing.
// The range limit is written through i_cfg_valid / o_cfg_ready / i_cfg_data
// while the block is idle; o_cfg_ready is always high.
// A word waits in the input register until the parse stage takes it, and
// the result of an ending word is loaded into the result register.
// Throughput: one word per cycle unless stalled, set by the update of the
// parse state (times-ten accumulate plus limit compare).
// While the receiver stalls, the held result stays; bytes that end no
// reply keep flowing, and a word that would end a reply waits in the input
// register, which then stalls the input channel.
// Reset (synchronous, active low) empties both registers, clears the parse
// state and sets the range limit to 10000.
`include "assert_macros.svh"

module ascii_distance_reply_parser_core #(
    parameter int MAX_BYTES = adrp_pkg::MAX_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  adrp_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output adrp_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);

    logic                r_in_valid;
    adrp_pkg::t_in_word  r_in_word;
    logic                r_out_valid;
    adrp_pkg::t_out_word r_out_word;
    logic [15:0]         r_range_limit;
    adrp_pkg::t_step_res parse_res;
    logic                out_free;
    logic                fire;

    // The parse stage moves when it holds a word and its result has room.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && (out_free || !parse_res.emit);
    assign o_in_stall = r_in_valid && !fire;
    assign o_cfg_ready = 1'b1;

    adrp_parse #(
        .MAX_BYTES(MAX_BYTES)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (fire),
        .i_word       (r_in_word),
        .i_range_limit(r_range_limit),
        .o_res        (parse_res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_in_word;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && parse_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && parse_res.emit) begin
            r_out_word <= parse_res.word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Range limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_limit <= adrp_pkg::RANGE_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_range_limit <= i_cfg_data;
        end
    end

    // A result never overwrites one the receiver has not taken.
    `ADRP_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, fire && parse_res.emit, out_free)
    // A word held back by a stalled output stays in the input register.
    `ADRP_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_valid && !fire, r_in_valid)
    // An ending word always shows a result on the next cycle.
    `ADRP_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, fire && parse_res.emit, r_out_valid)

endmodule

// ----- rtl/adrp_parse.sv -----
// Parse stage of the distance reply parser: holds the per-reply state and
// updates it with one word per cycle on i_step. Depends on adrp_pkg.
module adrp_parse #(
    parameter int MAX_BYTES = adrp_pkg::MAX_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  adrp_pkg::t_in_word  i_word,
    input  logic [15:0]         i_range_limit,
    output adrp_pkg::t_step_res o_res
);

    localparam int CNT_W = $clog2(MAX_BYTES + 1);

    // Per-reply state.
    adrp_pkg::t_phase r_phase, n_phase;
    logic [15:0]      r_mval, n_mval;
    logic [15:0]      r_run, n_run;
    logic             r_in_run, n_in_run;
    logic             r_fb_found, n_fb_found;
    logic [15:0]      r_fb_val, n_fb_val;
    logic             r_ended, n_ended;
    logic [CNT_W-1:0] r_count, n_count;

    // Next state after taking the word, and the result when the reply ends.
    always_comb begin
        logic             is_digit;
        logic [3:0]       digit;
        logic             take;
        adrp_pkg::t_phase s_phase;
        logic [15:0]      s_mval;
        logic [15:0]      s_run;
        logic             s_in_run;
        logic             s_fb_found;
        logic [15:0]      s_fb_val;
        logic             s_ended;
        logic [CNT_W-1:0] s_count;
        logic             f_found;
        logic [15:0]      f_val;
        logic [7:0]       b;

        b        = i_word.data_byte;
        is_digit = (b >= adrp_pkg::CH_ZERO) && (b <= adrp_pkg::CH_NINE);
        digit    = b[3:0];
        take     = (i_word.action == adrp_pkg::ACT_BYTE) && !r_ended
                   && (r_count < CNT_W'(MAX_BYTES));

        s_phase    = r_phase;
        s_mval     = r_mval;
        s_run      = r_run;
        s_in_run   = r_in_run;
        s_fb_found = r_fb_found;
        s_fb_val   = r_fb_val;
        s_ended    = r_ended;
        s_count    = r_count;

        if (take) begin
            s_count = r_count + CNT_W'(1);
            if (b == adrp_pkg::CH_NUL) begin
                s_ended = 1'b1;
            end else begin
                // Digit runs for the fallback rule.
                if (is_digit) begin
                    s_run    = adrp_pkg::acc10(r_run, digit);
                    s_in_run = 1'b1;
                end else if (r_in_run) begin
                    if (!r_fb_found && (r_run != 16'd0) && (r_run < i_range_limit)) begin
                        s_fb_found = 1'b1;
                        s_fb_val   = r_run;
                    end
                    s_in_run = 1'b0;
                    s_run    = 16'd0;
                end

                // Marker match and the value that follows it.
                case (r_phase)
                    adrp_pkg::PH_SEARCH: begin
                        if (b == adrp_pkg::CH_D) s_phase = adrp_pkg::PH_SAW_D;
                    end
                    adrp_pkg::PH_SAW_D: begin
                        if (b == adrp_pkg::CH_COLON) s_phase = adrp_pkg::PH_SPACES;
                        else if (b != adrp_pkg::CH_D) s_phase = adrp_pkg::PH_SEARCH;
                    end
                    adrp_pkg::PH_SPACES: begin
                        if (is_digit) begin
                            s_mval  = {12'd0, digit};
                            s_phase = adrp_pkg::PH_DIGITS;
                        end else if (b != adrp_pkg::CH_SPACE) begin
                            s_phase = adrp_pkg::PH_FAILED;
                        end
                    end
                    adrp_pkg::PH_DIGITS: begin
                        if (is_digit) s_mval = adrp_pkg::acc10(r_mval, digit);
                        else s_phase = adrp_pkg::PH_DONE;
                    end
                    default: begin
                    end
                endcase
            end
        end

        // A run still open at the end of the reply is closed here.
        f_found = s_fb_found;
        f_val   = s_fb_val;
        if (s_in_run && !s_fb_found && (s_run != 16'd0) && (s_run < i_range_limit)) begin
            f_found = 1'b1;
            f_val   = s_run;
        end

        // Result selection.
        o_res.emit               = (i_word.action == adrp_pkg::ACT_TIMEOUT) || i_word.last;
        o_res.word.distance      = 16'd0;
        o_res.word.used_fallback = 1'b0;
        if ((i_word.action == adrp_pkg::ACT_TIMEOUT) && (r_count == '0)) begin
            o_res.word.status = adrp_pkg::ST_TIMEOUT;
        end else if ((s_phase == adrp_pkg::PH_DIGITS) || (s_phase == adrp_pkg::PH_DONE)) begin
            o_res.word.distance = s_mval;
            o_res.word.status   = (s_mval > i_range_limit) ? adrp_pkg::ST_RANGE
                                                           : adrp_pkg::ST_OK;
        end else if (f_found) begin
            o_res.word.distance      = f_val;
            o_res.word.status        = adrp_pkg::ST_OK;
            o_res.word.used_fallback = 1'b1;
        end else begin
            o_res.word.status = adrp_pkg::ST_PARSE;
        end

        // A finished reply leaves the state cleared for the next one.
        n_phase    = s_phase;
        n_mval     = s_mval;
        n_run      = s_run;
        n_in_run   = s_in_run;
        n_fb_found = s_fb_found;
        n_fb_val   = s_fb_val;
        n_ended    = s_ended;
        n_count    = s_count;
        if (o_res.emit) begin
            n_phase    = adrp_pkg::PH_SEARCH;
            n_mval     = 16'd0;
            n_run      = 16'd0;
            n_in_run   = 1'b0;
            n_fb_found = 1'b0;
            n_fb_val   = 16'd0;
            n_ended    = 1'b0;
            n_count    = '0;
        end
    end

    // State registers advance only when the stage takes a word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= adrp_pkg::PH_SEARCH;
            r_mval     <= 16'd0;
            r_run      <= 16'd0;
            r_in_run   <= 1'b0;
            r_fb_found <= 1'b0;
            r_fb_val   <= 16'd0;
            r_ended    <= 1'b0;
            r_count    <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_mval     <= n_mval;
            r_run      <= n_run;
            r_in_run   <= n_in_run;
            r_fb_found <= n_fb_found;
            r_fb_val   <= n_fb_val;
            r_ended    <= n_ended;
            r_count    <= n_count;
        end
    end

endmodule

// ----- verif/adrp_reply_checker.sv -----
// Checker for the distance reply parser: watches the input, output and
// configuration channels, predicts every result word and compares them.
// Depends on adrp_pkg for the word types, status codes and characters.
`timescale 1ns / 1ps

module adrp_reply_checker #(
    parameter int MAX_BYTES = adrp_pkg::MAX_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  adrp_pkg::t_in_word  i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  adrp_pkg::t_out_word i_out_word,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [15:0]         i_cfg_data,
    output int                  o_pending,
    output int                  o_fail_count
);
    import adrp_pkg::*;

    // Our own copy of the parse state and the limit register.
    logic [15:0] limit_reg;
    t_phase      match_step;
    logic [15:0] marker_sum;
    logic [15:0] digit_sum;
    logic        digits_open;
    logic        spare_ok;
    logic [15:0] spare_value;
    logic        text_closed;
    int          byte_count;

    // Result words still owed by the block, oldest first.
    t_out_word   awaited_replies[$];

    function automatic logic [15:0] times_ten_plus(input logic [15:0] v, input logic [3:0] d);
        int unsigned full;
        full = v * 10 + d;
        return full[15:0];
    endfunction

    task automatic clear_reply();
        match_step  = PH_SEARCH;
        marker_sum  = '0;
        digit_sum   = '0;
        digits_open = 1'b0;
        spare_ok    = 1'b0;
        spare_value = '0;
        text_closed = 1'b0;
        byte_count  = 0;
    endtask

    // A digit run just ended; the first one strictly inside (0, limit) is kept.
    task automatic end_digit_run();
        if (digits_open) begin
            if (!spare_ok && digit_sum > 0 && digit_sum < limit_reg) begin
                spare_ok    = 1'b1;
                spare_value = digit_sum;
            end
            digits_open = 1'b0;
            digit_sum   = '0;
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        logic       is_dig;
        logic [3:0] d;
        is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
        d      = is_dig ? b[3:0] : 4'd0;
        // Bytes past the end of text or past the byte budget are dropped.
        if (text_closed || byte_count >= MAX_BYTES) return;
        byte_count++;
        if (b == CH_NUL) begin
            text_closed = 1'b1;
            return;
        end
        // Track any digit run for the fallback rule.
        if (is_dig) begin
            digit_sum   = times_ten_plus(digit_sum, d);
            digits_open = 1'b1;
        end else begin
            end_digit_run();
        end
        // Advance the "d:" marker match.
        case (match_step)
            PH_SEARCH: begin
                if (b == CH_D) match_step = PH_SAW_D;
            end
            PH_SAW_D: begin
                if (b == CH_COLON) match_step = PH_SPACES;
                else if (b != CH_D) match_step = PH_SEARCH;
            end
            PH_SPACES: begin
                if (is_dig) begin
                    marker_sum = {12'd0, d};
                    match_step = PH_DIGITS;
                end else if (b != CH_SPACE) begin
                    match_step = PH_FAILED;
                end
            end
            PH_DIGITS: begin
                if (is_dig) marker_sum = times_ten_plus(marker_sum, d);
                else match_step = PH_DONE;
            end
            default: ;
        endcase
    endtask

    // Works out the result word of a reply that has just ended.
    task automatic settle_reply(output t_out_word r);
        end_digit_run();
        r.distance      = '0;
        r.used_fallback = 1'b0;
        if (match_step == PH_DIGITS || match_step == PH_DONE) begin
            r.distance = marker_sum;
            r.status   = (marker_sum > limit_reg) ? ST_RANGE : ST_OK;
        end else if (spare_ok) begin
            r.distance      = spare_value;
            r.status        = ST_OK;
            r.used_fallback = 1'b1;
        end else begin
            r.status = ST_PARSE;
        end
    endtask

    task automatic parse_word(input t_in_word w, output bit produced, output t_out_word r);
        produced = 1'b0;
        r        = '0;
        if (w.action == ACT_TIMEOUT) begin
            if (byte_count == 0) r.status = ST_TIMEOUT;
            else settle_reply(r);
            clear_reply();
            produced = 1'b1;
        end else begin
            absorb_byte(w.data_byte);
            if (w.last) begin
                settle_reply(r);
                clear_reply();
                produced = 1'b1;
            end
        end
    endtask

    task automatic note_mismatch(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10) $display("%0t checker: %s", $realtime, msg);
    endtask

    // All channels are sampled at the rising edge, before the block updates.
    always @(posedge i_clk) begin : watch
        bit        produced;
        t_out_word want;
        t_out_word got;
        if (!i_rst_n) begin
            clear_reply();
            limit_reg = RANGE_LIMIT_RST;
            awaited_replies.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) limit_reg = i_cfg_data;

            // Compare each accepted result word with the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                got = i_out_word;
                if (awaited_replies.size() == 0) begin
                    note_mismatch($sformatf(
                        "unexpected word: status %0d distance %0d fallback %0d",
                        got.status, got.distance, got.used_fallback));
                end else begin
                    want = awaited_replies.pop_front();
                    if (got.status !== want.status)
                        note_mismatch($sformatf("status: expected %0d, got %0d",
                                                want.status, got.status));
                    if (got.distance !== want.distance)
                        note_mismatch($sformatf("distance: expected %0d, got %0d",
                                                want.distance, got.distance));
                    if (got.used_fallback !== want.used_fallback)
                        note_mismatch($sformatf("used_fallback: expected %0d, got %0d",
                                                want.used_fallback, got.used_fallback));
                end
            end

            // Predict from each accepted input word.
            if (i_in_valid && !i_in_stall) begin
                parse_word(i_in_word, produced, want);
                if (produced) awaited_replies.push_back(want);
            end
        end
        o_pending = awaited_replies.size();
    end

endmodule

// ----- verif/tb_ascii_distance_reply_parser_core.sv -----
// Testbench top of the distance reply parser: clock, reset, reply stimulus,
// limit writes and the verdict. Depends on adrp_pkg, the parser core and
// adrp_reply_checker, which predicts and compares the result words.
`timescale 1ns / 1ps

module tb_ascii_distance_reply_parser_core;
    import adrp_pkg::*;

    // How a reply is closed.
    typedef enum int {END_ON_LAST, END_ON_TIMEOUT} t_reply_end;

    // Kinds of random reply.
    typedef enum int {
        SHAPE_MARKED, SHAPE_BARE_DIGITS, SHAPE_NOISE, SHAPE_LONG, SHAPE_TIMEOUT_ONLY
    } t_reply_shape;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_word    in_word;
    logic        out_valid;
    logic        out_stall;
    t_out_word   out_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    int          pending;
    int          fail_count;

    logic [7:0]  reply_bytes[$];
    logic [15:0] limit_now;
    bit          calm;
    int unsigned words_sent;

    ascii_distance_reply_parser_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    adrp_reply_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Clock with a 2 ns period.
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard limit on the run time.
    initial begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

    // Idle cycles before a word; none during calm stretches.
    function automatic int unsigned draw_wait();
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    // Receiver: stalls a random number of cycles before taking each word.
    initial begin : receiver
        int unsigned hold;
        out_stall = 1'b0;
        @(negedge clk);
        forever begin
            hold = draw_wait();
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // Sends one word after a random gap and holds it until accepted.
    task automatic send_word(input t_in_word w);
        int unsigned gap;
        gap = draw_wait();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    task automatic stop_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) reply_bytes.push_back(s[i]);
    endtask

    // Sends the queued reply bytes and closes the reply.
    task automatic send_reply(input t_reply_end how);
        t_in_word w;
        if (how == END_ON_LAST && reply_bytes.size() == 0) push_text("x");
        for (int i = 0; i < reply_bytes.size(); i++) begin
            w.action    = ACT_BYTE;
            w.data_byte = reply_bytes[i];
            w.last      = (how == END_ON_LAST) && (i == reply_bytes.size() - 1);
            send_word(w);
        end
        if (how == END_ON_TIMEOUT) begin
            w.action    = ACT_TIMEOUT;
            w.data_byte = 8'($urandom_range(0, 255));
            w.last      = 1'($urandom_range(0, 1));
            send_word(w);
        end
        reply_bytes.delete();
        if ($urandom_range(0, 4) == 0) calm = !calm;
    endtask

    // Writes the range limit once the block has gone idle.
    task automatic write_limit(input logic [15:0] v);
        stop_input();
        wait (pending == 0);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        limit_now = v;
    endtask

    // Decimal text, biased toward the limit boundary and 16-bit wrap.
    function automatic string value_text();
        int v;
        case ($urandom_range(0, 4))
            0: begin
                v = int'(limit_now) + int'($urandom_range(0, 2)) - 1;
                if (v < 0) v = 0;
                return $sformatf("%0d", v);
            end
            1: return $sformatf("%0d", $urandom_range(0, 99));
            2: return $sformatf("%0d", $urandom_range(0, 65535));
            3: return $sformatf("%0d", $urandom_range(65536, 999999));
            default: return {"00", $sformatf("%0d", $urandom_range(0, 999))};
        endcase
    endfunction

    task automatic push_filler();
        case ($urandom_range(0, 7))
            0: push_text(" ");
            1: push_text("m");
            2: push_text("x");
            3: push_text("\r");
            4: push_text("\n");
            5: push_text($sformatf("%0d", $urandom_range(0, 9)));
            6: reply_bytes.push_back(CH_D);
            default: reply_bytes.push_back(CH_COLON);
        endcase
    endtask

    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'($urandom_range(0, 255));
            3: return CH_D;
            4: return CH_COLON;
            5: return CH_SPACE;
            6: return CH_NUL;
            default: return CH_ZERO + 8'($urandom_range(0, 9));
        endcase
    endfunction

    // A well-formed "d:" reply with random surroundings and occasional flaws.
    task automatic build_marked();
        repeat ($urandom_range(0, 4)) push_filler();
        if ($urandom_range(0, 4) == 0) reply_bytes.push_back(CH_D);
        push_text("d:");
        repeat ($urandom_range(0, 3)) reply_bytes.push_back(CH_SPACE);
        if ($urandom_range(0, 9) == 0) push_text("x");
        push_text(value_text());
        if ($urandom_range(0, 9) == 0) reply_bytes.push_back(CH_NUL);
        repeat ($urandom_range(0, 3)) push_filler();
    endtask

    task automatic random_phase(input int unsigned count);
        int unsigned  target;
        t_reply_shape shape;
        int unsigned  pick;
        t_reply_end   how;
        target = words_sent + count;
        while (words_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) shape = SHAPE_MARKED;
            else if (pick < 70) shape = SHAPE_BARE_DIGITS;
            else if (pick < 85) shape = SHAPE_NOISE;
            else if (pick < 92) shape = SHAPE_LONG;
            else shape = SHAPE_TIMEOUT_ONLY;
            how = ($urandom_range(0, 9) == 0) ? END_ON_TIMEOUT : END_ON_LAST;
            case (shape)
                SHAPE_MARKED: build_marked();
                SHAPE_BARE_DIGITS: begin
                    repeat ($urandom_range(0, 3)) push_filler();
                    push_text(value_text());
                    push_text(" ");
                    if ($urandom_range(0, 1) == 1) push_text(value_text());
                end
                SHAPE_NOISE: begin
                    repeat ($urandom_range(1, 12)) reply_bytes.push_back(noise_char());
                end
                SHAPE_LONG: begin
                    // May run past the byte budget, in which case a late marker is dropped.
                    repeat ($urandom_range(55, 66)) push_filler();
                    push_text("d:");
                    push_text(value_text());
                end
                default: how = END_ON_TIMEOUT;
            endcase
            send_reply(how);
        end
    endtask

    // Stimulus: reset, directed replies, then random phases over several limits.
    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_word    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        limit_now  = RANGE_LIMIT_RST;
        calm       = 1'b0;
        words_sent = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Timeout with no bytes.
        send_reply(END_ON_TIMEOUT);
        // Plain marker.
        push_text("d:5");
        send_reply(END_ON_LAST);
        // NUL as the first byte still counts as a byte.
        reply_bytes.push_back(CH_NUL);
        send_reply(END_ON_LAST);
        // Highest byte value alone.
        reply_bytes.push_back(8'hFF);
        send_reply(END_ON_LAST);
        // Timeout after bytes, value from the fallback rule.
        push_text("7");
        send_reply(END_ON_TIMEOUT);
        // Overlapping marker.
        push_text("dd:9");
        send_reply(END_ON_LAST);
        // Marker followed by no digit.
        push_text("d: x");
        send_reply(END_ON_LAST);
        // Digit run without a marker.
        push_text("a12b");
        send_reply(END_ON_LAST);

        random_phase(150);
        write_limit(16'd0);
        random_phase(120);
        write_limit(16'hFFFF);
        random_phase(150);
        write_limit(16'd1);
        random_phase(100);
        write_limit(16'($urandom_range(2, 65534)));
        random_phase(150);
        write_limit(RANGE_LIMIT_RST);
        random_phase(120);

        // Drain, then give the verdict.
        stop_input();
        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
